>>> rtl/cmfta_pkg.sv
// Shared constants and types for the cube map face and texel address block.
// Used by every module of the block; depends on nothing.
package cmfta_pkg;

  localparam int MAX_FACE_SIZE_DEF  = 4096;
  localparam int COMPONENT_BITS_DEF = 16;

  localparam int CFG_W    = 13;
  localparam int TEXEL_W  = 12;
  localparam int FACE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_W-1:0] FACE_SIZE_RST = CFG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACE_WIDTH  = 2'd0,
    REG_FACE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

endpackage

>>> rtl/cmfta_front.sv
// Front end: holds the face size registers, picks the major axis and face,
// and forms the biased coordinates. Depends on cmfta_pkg.
module cmfta_front #(
  parameter int MAX_FACE_SIZE  = cmfta_pkg::MAX_FACE_SIZE_DEF,
  parameter int COMPONENT_BITS = cmfta_pkg::COMPONENT_BITS_DEF,
  parameter int SB = $clog2(MAX_FACE_SIZE) + 1,
  parameter int PW = cmfta_pkg::FACE_W + 3*COMPONENT_BITS + 2 + 2*SB + 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cmfta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmfta_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [COMPONENT_BITS-1:0]       dir_x,
  input  logic [COMPONENT_BITS-1:0]       dir_y,
  input  logic [COMPONENT_BITS-1:0]       dir_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [PW-1:0]                   out_data
);

  localparam int CB = COMPONENT_BITS;

  logic [cmfta_pkg::CFG_W-1:0] face_width, face_height;
  logic [SB-1:0] eff_w, eff_h;
  logic signed [CB:0] sx, sy, sz, sc, tc;
  logic [CB-1:0] ax, ay, az, ma;
  logic [CB:0] a_x, a_y;
  cmfta_pkg::face_t face;
  logic deg;
  logic fv;
  logic [PW-1:0] payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_width  <= cmfta_pkg::FACE_SIZE_RST;
      face_height <= cmfta_pkg::FACE_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cmfta_pkg::REG_FACE_WIDTH:  face_width  <= cfg_data;
        cmfta_pkg::REG_FACE_HEIGHT: face_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero size acts as one; a size above the maximum is held at the maximum.
  always_comb begin
    if (face_width == '0) eff_w = SB'(1);
    else if (32'(face_width) > 32'(MAX_FACE_SIZE)) eff_w = SB'(MAX_FACE_SIZE);
    else eff_w = SB'(face_width);
    if (face_height == '0) eff_h = SB'(1);
    else if (32'(face_height) > 32'(MAX_FACE_SIZE)) eff_h = SB'(MAX_FACE_SIZE);
    else eff_h = SB'(face_height);
  end

  always_comb begin
    sx = $signed({dir_x[CB-1], dir_x});
    sy = $signed({dir_y[CB-1], dir_y});
    sz = $signed({dir_z[CB-1], dir_z});
    ax = CB'(sx[CB] ? -sx : sx);
    ay = CB'(sy[CB] ? -sy : sy);
    az = CB'(sz[CB] ? -sz : sz);
    deg = (ax == '0) && (ay == '0) && (az == '0);
    if (ax >= ay && ax >= az) begin
      ma = ax;
      tc = -sy;
      if (!sx[CB]) begin face = cmfta_pkg::FACE_PX; sc = -sz; end
      else begin face = cmfta_pkg::FACE_NX; sc = sz; end
    end else if (ay >= az) begin
      ma = ay;
      sc = sx;
      if (!sy[CB]) begin face = cmfta_pkg::FACE_PY; tc = sz; end
      else begin face = cmfta_pkg::FACE_NY; tc = -sz; end
    end else begin
      ma = az;
      tc = -sy;
      if (!sz[CB]) begin face = cmfta_pkg::FACE_PZ; sc = sx; end
      else begin face = cmfta_pkg::FACE_NZ; sc = -sx; end
    end
    // Bias by ma so both coordinates become non-negative numerators.
    a_x = CB'(0) + (CB+1)'(sc + $signed({1'b0, ma}));
    a_y = (CB+1)'(tc + $signed({1'b0, ma}));
  end

  assign in_ready = !fv || out_ready;
  assign out_valid = fv;
  assign out_data = payload;

  always_ff @(posedge clk) begin
    if (rst) fv <= 1'b0;
    else if (in_valid && in_ready) fv <= 1'b1;
    else if (out_ready) fv <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) payload <= {deg, eff_h, eff_w, ma, a_y, a_x, face};
  end

endmodule

>>> rtl/cmfta_fifo.sv
// Short register queue between the front end and the divider back end.
// Depends on cmfta_pkg for its depth.
module cmfta_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam int D  = cmfta_pkg::FIFO_DEPTH;
  localparam int AW = $clog2(D);

  logic [W-1:0] mem [D];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push, pop;

  assign in_ready  = cnt != (AW+1)'(D);
  assign out_valid = cnt != '0;
  assign out_data  = mem[rp];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + AW'(1);
      if (pop) rp <= rp + AW'(1);
      if (push && !pop) cnt <= cnt + (AW+1)'(1);
      else if (pop && !push) cnt <= cnt - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end

endmodule

>>> rtl/cmfta_back.sv
// Back end: scales the biased coordinates by the face size and divides by
// 2*ma in a pipelined restoring divider, one quotient bit per stage.
// Depends on cmfta_pkg.
module cmfta_back #(
  parameter int MAX_FACE_SIZE  = cmfta_pkg::MAX_FACE_SIZE_DEF,
  parameter int COMPONENT_BITS = cmfta_pkg::COMPONENT_BITS_DEF,
  parameter int SB = $clog2(MAX_FACE_SIZE) + 1,
  parameter int PW = cmfta_pkg::FACE_W + 3*COMPONENT_BITS + 2 + 2*SB + 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PW-1:0]                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cmfta_pkg::FACE_W-1:0]    face_index,
  output logic [cmfta_pkg::TEXEL_W-1:0]   texel_x,
  output logic [cmfta_pkg::TEXEL_W-1:0]   texel_y,
  output logic                            degenerate
);

  localparam int CB = COMPONENT_BITS;
  localparam int QB = SB;
  localparam int NB = CB + 1 + SB;
  localparam int FW = cmfta_pkg::FACE_W;

  logic [FW-1:0] i_face;
  logic [CB:0]   i_ax, i_ay;
  logic [CB-1:0] i_ma;
  logic [SB-1:0] i_w, i_h;
  logic          i_deg;

  assign {i_deg, i_h, i_w, i_ma, i_ay, i_ax, i_face} = in_data;

  logic          vld  [QB+1];
  logic [NB-1:0] remx [QB+1];
  logic [NB-1:0] remy [QB+1];
  logic [QB-1:0] qx   [QB+1];
  logic [QB-1:0] qy   [QB+1];
  logic [CB:0]   den  [QB+1];
  logic [SB-1:0] szw  [QB+1];
  logic [SB-1:0] szh  [QB+1];
  logic [FW-1:0] fc   [QB+1];
  logic          dg   [QB+1];

  logic adv;
  assign adv = !vld[QB] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      remx[0] <= NB'(i_ax * i_w);
      remy[0] <= NB'(i_ay * i_h);
      qx[0]   <= '0;
      qy[0]   <= '0;
      den[0]  <= {i_ma, 1'b0};
      szw[0]  <= i_w;
      szh[0]  <= i_h;
      fc[0]   <= i_face;
      dg[0]   <= i_deg;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [NB-1:0] trial;
    logic bx, by;
    assign trial = NB'(den[k-1]) << (QB - k);
    assign bx = remx[k-1] >= trial;
    assign by = remy[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (adv) vld[k] <= vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        remx[k] <= bx ? remx[k-1] - trial : remx[k-1];
        remy[k] <= by ? remy[k-1] - trial : remy[k-1];
        qx[k]   <= {qx[k-1][QB-2:0], bx};
        qy[k]   <= {qy[k-1][QB-2:0], by};
        den[k]  <= den[k-1];
        szw[k]  <= szw[k-1];
        szh[k]  <= szh[k-1];
        fc[k]   <= fc[k-1];
        dg[k]   <= dg[k-1];
      end
    end
  end

  // The quotient never exceeds the size, so the clamp only folds size to size-1.
  logic [QB-1:0] cx, cy;
  always_comb begin
    cx = (qx[QB] >= szw[QB]) ? szw[QB] - SB'(1) : qx[QB];
    cy = (qy[QB] >= szh[QB]) ? szh[QB] - SB'(1) : qy[QB];
  end

  assign out_valid  = vld[QB];
  assign degenerate = dg[QB];
  assign face_index = dg[QB] ? cmfta_pkg::FACE_PX : fc[QB];
  assign texel_x    = dg[QB] ? '0 : cmfta_pkg::TEXEL_W'(cx);
  assign texel_y    = dg[QB] ? '0 : cmfta_pkg::TEXEL_W'(cy);

  a_qx_bound: assert property (@(posedge clk) disable iff (rst)
    vld[QB] && !dg[QB] |-> qx[QB] <= szw[QB])
    else $error("x quotient above face width");
  a_qy_bound: assert property (@(posedge clk) disable iff (rst)
    vld[QB] && !dg[QB] |-> qy[QB] <= szh[QB])
    else $error("y quotient above face height");
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> texel_x == '0 && texel_y == '0 &&
      face_index == cmfta_pkg::FACE_PX)
    else $error("degenerate result not at origin of +X");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vld[QB] && !out_ready |=> vld[QB] && $stable(qx[QB]) && $stable(qy[QB]))
    else $error("last divider stage moved while stalled");

endmodule

>>> rtl/cube_map_face_texel_address.sv
// Top level of the cube map face and texel address block.
// Depends on cmfta_pkg, cmfta_front, cmfta_fifo and cmfta_back.
//
// Usage: a direction vector arrives as one transfer on the s_ channel and
// leaves as one transfer on the m_ channel holding the selected cube face
// and the texel column and row on that face; m_tuser flags a zero vector.
// The face size registers are written through cfg_we, cfg_index and
// cfg_data on a clock edge with cfg_we high; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// A new vector can be taken on every clock while m_tready stays high, so
// the sustained rate is one transfer per cycle. The accepting edge loads
// the front end register; from there a vector passes through the queue,
// the scaling multiply register and one divider stage per quotient bit
// before its result appears on m_.
// When the receiver holds m_tready low, the divider pipeline freezes, the
// four entry queue fills and then the front end stalls s_tready; no result
// is lost. Reset clears all valid flags and the queue and loads both face
// size registers with 256.
module cube_map_face_texel_address #(
  parameter int MAX_FACE_SIZE  = cmfta_pkg::MAX_FACE_SIZE_DEF,
  parameter int COMPONENT_BITS = cmfta_pkg::COMPONENT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cmfta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmfta_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0 up: dir_x, dir_y, dir_z, zero fill to whole bytes.
  input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0 up: face_index[2:0], texel_x[14:3], texel_y[26:15], zero fill.
  output logic [31:0]                     m_tdata,
  // Fields: degenerate.
  output logic                            m_tuser
);

  localparam int CB = COMPONENT_BITS;
  localparam int SB = $clog2(MAX_FACE_SIZE) + 1;
  localparam int PW = cmfta_pkg::FACE_W + 3*CB + 2 + 2*SB + 1;

  logic          f_valid, f_ready, q_valid, q_ready;
  logic [PW-1:0] f_data, q_data;
  logic [cmfta_pkg::FACE_W-1:0]  face_index;
  logic [cmfta_pkg::TEXEL_W-1:0] texel_x, texel_y;

  cmfta_front #(
    .MAX_FACE_SIZE (MAX_FACE_SIZE),
    .COMPONENT_BITS(COMPONENT_BITS),
    .SB            (SB),
    .PW            (PW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .dir_x    (s_tdata[CB-1:0]),
    .dir_y    (s_tdata[2*CB-1:CB]),
    .dir_z    (s_tdata[3*CB-1:2*CB]),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .out_data (f_data)
  );

  cmfta_fifo #(.W(PW)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  (f_data),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_data)
  );

  cmfta_back #(
    .MAX_FACE_SIZE (MAX_FACE_SIZE),
    .COMPONENT_BITS(COMPONENT_BITS),
    .SB            (SB),
    .PW            (PW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (q_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .face_index(face_index),
    .texel_x   (texel_x),
    .texel_y   (texel_y),
    .degenerate(m_tuser)
  );

  assign m_tdata = {5'd0, texel_y, texel_x, face_index};

endmodule

>>> test/tb_cube_map_face_texel_address.sv
// Testbench for the cube map face and texel address block: a table of
// directed vectors, then random vectors, checked against a local predictor.
// Depends on cmfta_pkg and cube_map_face_texel_address.
module tb_cube_map_face_texel_address;

  localparam int MAX_SIZE = 4096;
  localparam int LATENCY  = 20;
  localparam int WD_LIMIT = 5000;

  // One expected output transfer of the block.
  typedef struct packed {
    logic [cmfta_pkg::FACE_W-1:0]  face;
    logic [cmfta_pkg::TEXEL_W-1:0] tx;
    logic [cmfta_pkg::TEXEL_W-1:0] ty;
    logic                          degen;
  } lookup_t;

  // One row of the directed table; has_exp marks a typed-in result.
  typedef struct {
    logic signed [15:0] x, y, z;
    bit                 has_exp;
    lookup_t            exp;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [cmfta_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cmfta_pkg::CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic m_tuser;

  // Local copy of the two face size registers.
  logic [cmfta_pkg::CFG_W-1:0] width_reg = cmfta_pkg::CFG_W'(256);
  logic [cmfta_pkg::CFG_W-1:0] height_reg = cmfta_pkg::CFG_W'(256);

  lookup_t pending_lookups[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;

  always #10 clk = ~clk;

  cube_map_face_texel_address i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Register values of zero act as one and values past the maximum saturate.
  function automatic longint clip_size(logic [cmfta_pkg::CFG_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SIZE) return MAX_SIZE;
    return longint'(s);
  endfunction

  // floor((c+ma)*size/(2*ma)) limited to size-1, in exact integers.
  function automatic logic [cmfta_pkg::TEXEL_W-1:0] scale_coord(longint c, longint ma,
                                                               longint size);
    longint q;
    q = ((c + ma) * size) / (2 * ma);
    if (q > size - 1) q = size - 1;
    return cmfta_pkg::TEXEL_W'(q);
  endfunction

  // Face selection: largest magnitude wins, ties favor X, then Y, then Z.
  function automatic lookup_t map_direction(logic signed [15:0] dx,
                                            logic signed [15:0] dy,
                                            logic signed [15:0] dz);
    longint x, y, z, ax, ay, az, sc, tc, ma;
    cmfta_pkg::face_t f;
    lookup_t r;
    x = dx; y = dy; z = dz;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    r = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.degen = 1'b1;
      return r;
    end
    if (ax >= ay && ax >= az) begin
      ma = ax; tc = -y;
      if (x >= 0) begin f = cmfta_pkg::FACE_PX; sc = -z; end
      else begin f = cmfta_pkg::FACE_NX; sc = z; end
    end else if (ay >= az) begin
      ma = ay; sc = x;
      if (y >= 0) begin f = cmfta_pkg::FACE_PY; tc = z; end
      else begin f = cmfta_pkg::FACE_NY; tc = -z; end
    end else begin
      ma = az; tc = -y;
      if (z >= 0) begin f = cmfta_pkg::FACE_PZ; sc = x; end
      else begin f = cmfta_pkg::FACE_NZ; sc = -x; end
    end
    r.face = f;
    r.tx = scale_coord(sc, ma, clip_size(width_reg));
    r.ty = scale_coord(tc, ma, clip_size(height_reg));
    return r;
  endfunction

  // Writes one face size register; only called while the block is idle.
  task automatic write_size(cmfta_pkg::cfg_reg_t idx, logic [cmfta_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cmfta_pkg::REG_FACE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  // Offers one vector, holds it until a transfer happens, and records the
  // expected lookup. s_tvalid stays high; the caller lowers it for gaps.
  task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit has_exp, lookup_t exp);
    lookup_t p;
    s_tvalid <= 1'b1;
    s_tdata <= {x, y, z} == 0 ? 48'd0 : {z, y, x};
    p = map_direction(x, y, z);
    if (has_exp) p = exp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_lookups.push_back(p);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Waits for every expected lookup to arrive, then idles for the LATENCY settling time.
  task automatic drain;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp;
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random vector; some have tied magnitudes to hit face edges and corners.
  task automatic random_vector;
    logic signed [15:0] x, y, z, m;
    x = rand_comp(); y = rand_comp(); z = rand_comp();
    if ($urandom_range(0, 7) == 0) begin
      m = 16'($urandom_range(1, 32767));
      x = $urandom_range(0, 1) ? m : -m;
      y = $urandom_range(0, 1) ? m : -m;
      if ($urandom_range(0, 1)) z = $urandom_range(0, 1) ? m : -m;
    end
    send_vector(x, y, z, 1'b0, '0);
  endtask

  // Output checker: each transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result face=%0d x=%0d y=%0d degen=%0d", $time,
                 m_tdata[2:0], m_tdata[14:3], m_tdata[26:15], m_tuser);
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        if (m_tdata[2:0] !== want.face) begin
          $display("%0t: face expected %0d actual %0d", $time, want.face, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[14:3] !== want.tx) begin
          $display("%0t: texel_x expected %0d actual %0d", $time, want.tx, m_tdata[14:3]);
          errors++;
        end
        if (m_tdata[26:15] !== want.ty) begin
          $display("%0t: texel_y expected %0d actual %0d", $time, want.ty, m_tdata[26:15]);
          errors++;
        end
        if (m_tuser !== want.degen) begin
          $display("%0t: degenerate expected %0d actual %0d", $time, want.degen, m_tuser);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, stretches of steady acceptance, and a long
  // hold-off when requested so that the internal queue fills.
  initial begin
    int mode;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(4, 30)) begin
        m_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) != 0);
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb_cube_map_face_texel_address failed");
      $finish;
    end
  end

  vec_row_t dir_table[$];

  function automatic vec_row_t row(logic signed [15:0] x, logic signed [15:0] y,
                                   logic signed [15:0] z, bit he,
                                   logic [2:0] f, int tx, int ty, bit d);
    vec_row_t r;
    r.x = x; r.y = y; r.z = z; r.has_exp = he;
    r.exp.face = f;
    r.exp.tx = cmfta_pkg::TEXEL_W'(tx);
    r.exp.ty = cmfta_pkg::TEXEL_W'(ty);
    r.exp.degen = d;
    return r;
  endfunction

  // Main sequence: directed table at reset sizes, then random phases over
  // several face size settings, including zero, one, odd and oversize.
  initial begin
    logic [cmfta_pkg::CFG_W-1:0] sizes[$];
    int burst;
    int sent;
    // Zero vector, each axis both ways, the most negative value, ties.
    dir_table.push_back(row(0, 0, 0, 1, cmfta_pkg::FACE_PX, 0, 0, 1));
    // +X center: sc=0, tc=0 -> 128,128 at size 256.
    dir_table.push_back(row(16'sd16384, 0, 0, 1, cmfta_pkg::FACE_PX, 128, 128, 0));
    dir_table.push_back(row(-16'sd16384, 0, 0, 1, cmfta_pkg::FACE_NX, 128, 128, 0));
    dir_table.push_back(row(0, 16'sd100, 0, 1, cmfta_pkg::FACE_PY, 128, 128, 0));
    dir_table.push_back(row(0, -16'sd100, 0, 1, cmfta_pkg::FACE_NY, 128, 128, 0));
    dir_table.push_back(row(0, 0, 16'sd1, 1, cmfta_pkg::FACE_PZ, 128, 128, 0));
    dir_table.push_back(row(0, 0, -16'sd1, 1, cmfta_pkg::FACE_NZ, 128, 128, 0));
    dir_table.push_back(row(16'sh8000, 0, 0, 1, cmfta_pkg::FACE_NX, 128, 128, 0));
    dir_table.push_back(row(16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0));
    dir_table.push_back(row(16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0));
    dir_table.push_back(row(16'sh8000, 16'sh7fff, 16'sh8000, 0, 0, 0, 0, 0));
    dir_table.push_back(row(0, 16'sh7fff, 16'sh8000, 0, 0, 0, 0, 0));
    dir_table.push_back(row(0, 16'sh8000, 16'sh7fff, 0, 0, 0, 0, 0));
    dir_table.push_back(row(16'sd5, -16'sd5, 16'sd5, 0, 0, 0, 0, 0));
    dir_table.push_back(row(-16'sd7, 16'sd7, -16'sd7, 0, 0, 0, 0, 0));
    dir_table.push_back(row(16'sd3, 16'sd1, -16'sd9, 0, 0, 0, 0, 0));
    dir_table.push_back(row(16'sh7fff, -16'sd1, 16'sd1, 0, 0, 0, 0, 0));
    dir_table.push_back(row(-16'sd1, 16'sd1, 16'sh8000, 0, 0, 0, 0, 0));
    dir_table.push_back(row(16'sh5555, 16'shaaaa, 16'sh1234, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      send_vector(dir_table[i].x, dir_table[i].y, dir_table[i].z,
                  dir_table[i].has_exp, dir_table[i].exp);
      gap($urandom_range(0, 2));
    end
    gap(1);
    drain();

    sizes = {cmfta_pkg::CFG_W'(0), cmfta_pkg::CFG_W'(1), cmfta_pkg::CFG_W'(4096),
             cmfta_pkg::CFG_W'(8191), cmfta_pkg::CFG_W'(7), cmfta_pkg::CFG_W'(1000),
             cmfta_pkg::CFG_W'(256), cmfta_pkg::CFG_W'(4097), cmfta_pkg::CFG_W'(3)};
    foreach (sizes[p]) begin
      write_size(cmfta_pkg::REG_FACE_WIDTH, sizes[p]);
      write_size(cmfta_pkg::REG_FACE_HEIGHT,
                 (p % 2) ? sizes[(p + 3) % sizes.size()] : cmfta_pkg::CFG_W'($urandom));
      // Bursts of random length until about thirty vectors went out.
      sent = 0;
      while (sent < 30) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          random_vector();
          sent++;
        end
        gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
      end
      gap(1);
      drain();
    end
    // Send 120 more vectors at the last setting, with the receiver holding
    // off for a while so the block backs up.
    hold_off = 1'b1;
    repeat (120) begin
      random_vector();
      gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
    end
    gap(1);
    drain();

    if (errors == 0) $display("tb_cube_map_face_texel_address passed");
    else $display("tb_cube_map_face_texel_address failed");
    $finish;
  end

endmodule
